// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL; all sample on clk and go quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: always");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next");

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same");

`endif

// ===== sv/nec_ir_pkg.sv =====
// Shared types and constants for the NEC IR frame decoder.
`timescale 1ns / 1ps

package nec_ir_pkg;

	localparam int FRAME_BITS = 32;
	localparam int EDGE_W     = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int PHASE_W    = 6;

	localparam logic [PHASE_W-1:0] PH_ARMED  = PHASE_W'(0);
	localparam logic [PHASE_W-1:0] PH_LEADER = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PH_DATA0  = PHASE_W'(2);
	localparam logic [PHASE_W-1:0] PH_DONE   = PHASE_W'(2 + FRAME_BITS);

	localparam logic KIND_EDGE  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ONE_GAP    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MAX = CFG_IDX_W'(2);

	localparam logic [CFG_W-1:0] ONE_GAP_RST    = CFG_W'(1600);
	localparam logic [CFG_W-1:0] LEADER_MIN_RST = CFG_W'(13000);
	localparam logic [CFG_W-1:0] LEADER_MAX_RST = CFG_W'(14000);

	typedef struct packed {
		logic [CFG_W-1:0] one_gap;
		logic [CFG_W-1:0] leader_min;
		logic [CFG_W-1:0] leader_max;
	} cfg_t;

	typedef struct packed {
		logic        frame_done;
		logic        error_flag;
		logic [15:0] address;
		logic        address_short;
		logic [7:0]  command;
	} result_t;

endpackage

// ===== sv/nec_ir_frame_decoder.sv =====
// NEC infrared frame decoder top level: input register, frame core, result register.
`timescale 1ns / 1ps

// Takes falling-edge timestamps (kind 0) or clear requests (kind 1), one item per
// cycle unless stalled, and returns one result per item showing the decoder state
// after that item. Each item lands in an input register, the frame update and
// result formatting run in a single combinational pass, and the result is held in
// an output register. The input stays ready while a result waits, as long as the
// input register is free or the result moves. The user writes configuration only
// while the decoder is idle, unenforced; configuration registers survive clear.
`include "assert_macros.svh"

module nec_ir_frame_decoder
	import nec_ir_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [EDGE_W-1:0]    edge_time_us,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 frame_done,
	output logic                 error_flag,
	output logic [15:0]          address,
	output logic                 address_short,
	output logic [7:0]           command
);

	logic              valid_s1;
	logic              kind_s1;
	logic [EDGE_W-1:0] time_s1;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res_nxt;
	cfg_t              cfg;
	logic              in_xfer;
	logic              advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;

	nec_ir_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	nec_ir_frame_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.kind         (kind_s1),
		.edge_time_us (time_s1),
		.cfg          (cfg),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1 <= kind;
			time_s1 <= edge_time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign frame_done    = res_q.frame_done;
	assign error_flag    = res_q.error_flag;
	assign address       = res_q.address;
	assign address_short = res_q.address_short;
	assign command       = res_q.command;

	// input only stalls when both stages are full and the result is held
	`ASSERT_SAME(a_stall_cause, !in_ready, valid_s1 && out_valid_q && !out_ready)
	// a drained output with nothing behind it goes empty
	`ASSERT_NEXT(a_drain, out_valid_q && out_ready && !valid_s1, !out_valid_q)
	// short address form only on a finished frame, and then the high byte is zero
	`ASSERT_SAME(a_short_done, out_valid_q && address_short,
		frame_done && address[15:8] == 8'h00)
	// a clear always yields an idle, error-free result
	`ASSERT_NEXT(a_clear, advance && kind_s1 == KIND_CLEAR,
		!res_q.frame_done && !res_q.error_flag)

endmodule

// ===== sv/nec_ir_cfg_regs.sv =====
// Configuration register file: edge gap threshold and leader window.
`timescale 1ns / 1ps

module nec_ir_cfg_regs
	import nec_ir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_gap    <= ONE_GAP_RST;
			cfg_q.leader_min <= LEADER_MIN_RST;
			cfg_q.leader_max <= LEADER_MAX_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ONE_GAP:    cfg_q.one_gap    <= wr_data;
				CFG_LEADER_MIN: cfg_q.leader_min <= wr_data;
				CFG_LEADER_MAX: cfg_q.leader_max <= wr_data;
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/nec_ir_frame_core.sv =====
// Frame state (phase, shift word, last edge time, sticky error) and per-item update.
`timescale 1ns / 1ps

module nec_ir_frame_core
	import nec_ir_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              kind,
	input  logic [EDGE_W-1:0] edge_time_us,
	input  cfg_t              cfg,
	output result_t           res
);

	logic [TIME_BITS-1:0]  last_q, last_d;
	logic [PHASE_W-1:0]    phase_q, phase_d;
	logic [FRAME_BITS-1:0] word_q, word_d;
	logic                  err_q, err_d;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] gap;
	logic                 bit_val;
	logic                 leader_ok;
	logic [15:0]          addr_word;
	logic                 short_form;
	logic                 done;

	assign now       = TIME_BITS'(edge_time_us);
	assign gap       = now - last_q;   // wraps modulo 2^TIME_BITS
	assign bit_val   = gap > TIME_BITS'(cfg.one_gap);
	assign leader_ok = (gap >= TIME_BITS'(cfg.leader_min)) &&
		(gap <= TIME_BITS'(cfg.leader_max));

	always_comb begin
		last_d  = last_q;
		phase_d = phase_q;
		word_d  = word_q;
		err_d   = err_q;
		if (kind == KIND_CLEAR) begin
			last_d  = '0;
			phase_d = PH_ARMED;
			word_d  = '0;
			err_d   = 1'b0;
		end else if (phase_q != PH_DONE) begin
			last_d = now;
			priority if (phase_q == PH_ARMED) begin
				phase_d = PH_LEADER;
			end else if (phase_q == PH_LEADER) begin
				if (leader_ok) begin
					phase_d = PH_DATA0;
				end else begin
					phase_d = PH_ARMED;
					err_d   = 1'b1;
				end
			end else begin
				word_d  = {word_q[FRAME_BITS-2:0], bit_val};
				phase_d = phase_q + PHASE_W'(1);
				// command byte must be the inverse of the byte above it
				if (phase_d == PH_DONE && word_d[7:0] != ~word_d[15:8])
					err_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			phase_q <= PH_ARMED;
			word_q  <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			last_q  <= last_d;
			phase_q <= phase_d;
			word_q  <= word_d;
			err_q   <= err_d;
		end
	end

	// result reflects the state after this item
	assign done       = phase_d == PH_DONE;
	assign addr_word  = word_d[31:16];
	assign short_form = addr_word[7:0] == ~addr_word[15:8];

	always_comb begin
		res.frame_done    = done;
		res.error_flag    = err_d;
		res.address       = '0;
		res.address_short = 1'b0;
		res.command       = '0;
		if (done) begin
			res.address       = short_form ? {8'h00, addr_word[7:0]} : addr_word;
			res.address_short = short_form;
			res.command       = word_d[7:0];
		end
	end

endmodule
